// File: rtl/core/fmb_pkg.sv
// ----------------------------------------------------------------------------
// fmb_pkg: shared types and constants of the FSMN memory block
// Sizes of the history and coefficient stores, item structs and MAC tags.
// ----------------------------------------------------------------------------
package fmb_pkg;

	localparam int MAX_LEN     = 512;
	localparam int MAX_ROWS    = 64;
	localparam int MAX_TAPS    = 32;
	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS   = 16;

	localparam int COL_W   = $clog2(MAX_LEN);
	localparam int LEN_W   = 10;
	localparam int PHYS_W  = $clog2(MAX_ROWS);
	localparam int ROWS_W  = 7;
	localparam int TAP_W   = 6;
	localparam int ROW_W   = 13;
	localparam int HADDR_W = PHYS_W + COL_W;
	localparam int CADDR_W = 14;
	localparam int HIST_DEPTH = MAX_ROWS * MAX_LEN;
	localparam int COEF_DEPTH = MAX_TAPS * MAX_LEN;
	localparam int ACC_W   = 40;
	localparam int FC_W    = 17;
	localparam logic [FC_W-1:0] COUNT_MAX = '1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HISTORY_ROWS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAST_ORDER    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FUTURE_ORDER  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAST_STRIDE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FUTURE_STRIDE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WARMUP_FRAMES = 3'd6;

	// Commands
	localparam logic [1:0] CMD_LOAD_PAST = 2'd0;
	localparam logic [1:0] CMD_LOAD_FUT  = 2'd1;
	localparam logic [1:0] CMD_PUSH      = 2'd2;

	typedef struct packed {
		logic [1:0]                    cmd;
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [CADDR_W-1:0]            coef_addr;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] result;
		logic                          frame_end;
		logic                          saturated;
	} out_item_t;

	// One product term issued to the MAC
	typedef struct packed {
		logic valid;
		logic plain;
		logic future;
		logic zero;
	} mac_tag_t;

endpackage

// File: rtl/core/fmb_ram.sv
// ----------------------------------------------------------------------------
// fmb_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fmb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/fmb_mac.sv
// ----------------------------------------------------------------------------
// fmb_mac: shared multiply-accumulate unit
// Multiplies one coefficient by one history sample per cycle, sums the
// terms and rounds the total to Q7.8 with saturation.
// ----------------------------------------------------------------------------
module fmb_mac (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     clear,
	input  fmb_pkg::mac_tag_t                        tag,
	input  logic signed [fmb_pkg::COEF_BITS-1:0]     past_coef,
	input  logic signed [fmb_pkg::COEF_BITS-1:0]     fut_coef,
	input  logic signed [fmb_pkg::SAMPLE_BITS-1:0]   hist_sample,
	output logic signed [fmb_pkg::SAMPLE_BITS-1:0]   result,
	output logic                                     saturated
);
	import fmb_pkg::*;

	localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
	localparam int RND_W  = ACC_W - 14;

	mac_tag_t                  tag_s1;
	logic                      valid_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [PROD_W-1:0]  prod_c;
	logic signed [COEF_BITS-1:0] coef_c;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   rnd_c;
	logic signed [RND_W-1:0]   quo_c;

	// Align the tag with the registered memory data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag;
		end
	end

	// Select the product: plain row is scaled by 2^14, masked taps add zero
	always_comb begin
		coef_c = tag_s1.future ? fut_coef : past_coef;
		if (tag_s1.zero) begin
			prod_c = '0;
		end else if (tag_s1.plain) begin
			prod_c = PROD_W'(hist_sample) <<< 14;
		end else begin
			prod_c = coef_c * hist_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= tag_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod_c;
	end

	// Accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clear) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Round half up to Q7.8 and clip
	always_comb begin
		rnd_c = acc_q + ACC_W'(1 <<< 13);
		quo_c = RND_W'(rnd_c >>> 14);
		saturated = 1'b0;
		result = quo_c[SAMPLE_BITS-1:0];
		if (quo_c > RND_W'(32767)) begin
			result = 16'sh7FFF;
			saturated = 1'b1;
		end else if (quo_c < -RND_W'(32768)) begin
			result = 16'sh8000;
			saturated = 1'b1;
		end
	end

endmodule

// File: rtl/core/fsmn_memory_block_core.sv
// ----------------------------------------------------------------------------
// fsmn_memory_block_core: strided FSMN memory filter
// Per-column past/future tap filter over a ring of stored frames.
// ----------------------------------------------------------------------------
// After reset the block clears its 32768-entry history store, one entry per
// cycle, and holds in_stall high until the clear is done; configuration
// writes are taken throughout. A coefficient load is written as it is taken.
// A frame element passes through setup, one step per tap through the shared
// multiply-accumulate unit (one memory read per cycle), the plain row, a
// drain step and writeback. When history_rows was lowered below the newest
// row index, setup subtracts history_rows until that index is in range. The
// next request is taken once the block is back in idle.
// ----------------------------------------------------------------------------
module fsmn_memory_block_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  fmb_pkg::in_item_t                   in_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output fmb_pkg::out_item_t                  out_item,
	input  logic                                cfg_write,
	input  logic [fmb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fmb_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import fmb_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_MOD, S_WRITE, S_PAST, S_PLAIN, S_FUT, S_DRAIN, S_DONE
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [LEN_W-1:0]  frame_length_q;
	logic [ROWS_W-1:0] history_rows_q;
	logic [TAP_W-1:0]  past_order_q, future_order_q, past_stride_q, future_stride_q;
	logic [15:0]       warmup_q;

	// Block state
	logic [PHYS_W-1:0] newest_row_q;
	logic [FC_W-1:0]   frame_count_q;
	logic [COL_W-1:0]  column_q;

	// Per-request working registers
	logic [LEN_W-1:0]  len_q;
	logic [ROWS_W-1:0] rows_q;
	logic [TAP_W-1:0]  po_q, fo_q, k_q;
	logic [COL_W-1:0]  col_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic              store_q;
	logic [PHYS_W-1:0] nrm_q;
	logic [ROW_W-1:0]  row_q;
	logic [CADDR_W-1:0] paddr_q, faddr_q;
	logic              drain_q;
	logic [HADDR_W:0]  clr_q;

	logic              out_valid_q;
	out_item_t         out_item_q;

	// Clamped configuration and request setup
	logic [LEN_W-1:0]  len_c;
	logic [ROWS_W-1:0] rows_c;
	logic [TAP_W-1:0]  po_c, fo_c;
	logic [COL_W-1:0]  col_c;
	logic [FC_W-1:0]   fc_c;
	logic              accept;
	logic [ROWS_W-1:0] nr_inc_c;

	// Issue path
	logic              rv_c;
	logic [ROWS_W:0]   sum_c;
	logic [ROWS_W:0]   phys_c;
	mac_tag_t          tag_c;

	// Memory ports
	logic              h_we;
	logic [HADDR_W-1:0] h_waddr, h_raddr;
	logic [SAMPLE_BITS-1:0] h_wdata, h_rdata;
	logic [COEF_BITS-1:0] pc_rdata, fc_rdata;
	logic              pc_we, fc_we;

	logic signed [SAMPLE_BITS-1:0] mac_result;
	logic              mac_sat;
	logic              mac_clear;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_comb begin
		if (frame_length_q == '0) len_c = LEN_W'(1);
		else if (frame_length_q > LEN_W'(MAX_LEN)) len_c = LEN_W'(MAX_LEN);
		else len_c = frame_length_q;
		if (history_rows_q == '0) rows_c = ROWS_W'(1);
		else if (history_rows_q > ROWS_W'(MAX_ROWS)) rows_c = ROWS_W'(MAX_ROWS);
		else rows_c = history_rows_q;
		if (past_order_q == '0) po_c = TAP_W'(1);
		else if (past_order_q > TAP_W'(MAX_TAPS)) po_c = TAP_W'(MAX_TAPS);
		else po_c = past_order_q;
		fo_c = (future_order_q > TAP_W'(MAX_TAPS)) ? TAP_W'(MAX_TAPS) : future_order_q;
		col_c = ({1'b0, column_q} < len_c) ? column_q : '0;
		fc_c = (col_c == '0 && frame_count_q != COUNT_MAX) ? frame_count_q + 1'b1
			: frame_count_q;
		nr_inc_c = ({1'b0, nrm_q} + 1'b1 == rows_q) ? '0 : {1'b0, nrm_q} + 1'b1;
	end

	// Map the logical row to its physical row in the ring
	always_comb begin
		rv_c   = row_q < ROW_W'(rows_q);
		sum_c  = {2'b0, nrm_q} + (ROWS_W+1)'(1) + {1'b0, row_q[ROWS_W-1:0]};
		phys_c = (sum_c >= {1'b0, rows_q}) ? sum_c - {1'b0, rows_q} : sum_c;
		tag_c  = '0;
		case (state_q)
			S_PAST: begin
				tag_c.valid = 1'b1;
				tag_c.zero  = !rv_c;
			end
			S_PLAIN: begin
				tag_c.valid = 1'b1;
				tag_c.plain = 1'b1;
				tag_c.zero  = !rv_c;
			end
			S_FUT: begin
				tag_c.valid  = 1'b1;
				tag_c.future = 1'b1;
				tag_c.zero   = !rv_c;
			end
			default: tag_c = '0;
		endcase
	end

	assign h_raddr = {phys_c[PHYS_W-1:0], col_q};
	assign h_we    = (state_q == S_CLEAR) || (state_q == S_WRITE && store_q);
	assign h_waddr = (state_q == S_CLEAR) ? clr_q[HADDR_W-1:0] : {nrm_q, col_q};
	assign h_wdata = (state_q == S_CLEAR) ? '0 : sample_q;
	assign pc_we   = accept && in_item.cmd == CMD_LOAD_PAST;
	assign fc_we   = accept && in_item.cmd == CMD_LOAD_FUT;
	assign mac_clear = (state_q == S_WRITE);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q  <= LEN_W'(1);
			history_rows_q  <= ROWS_W'(1);
			past_order_q    <= TAP_W'(1);
			future_order_q  <= '0;
			past_stride_q   <= TAP_W'(1);
			future_stride_q <= TAP_W'(1);
			warmup_q        <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_LENGTH:  frame_length_q  <= cfg_data[LEN_W-1:0];
				REG_HISTORY_ROWS:  history_rows_q  <= cfg_data[ROWS_W-1:0];
				REG_PAST_ORDER:    past_order_q    <= cfg_data[TAP_W-1:0];
				REG_FUTURE_ORDER:  future_order_q  <= cfg_data[TAP_W-1:0];
				REG_PAST_STRIDE:   past_stride_q   <= cfg_data[TAP_W-1:0];
				REG_FUTURE_STRIDE: future_stride_q <= cfg_data[TAP_W-1:0];
				REG_WARMUP_FRAMES: warmup_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			newest_row_q  <= '0;
			frame_count_q <= '0;
			column_q      <= '0;
			out_valid_q   <= 1'b0;
			drain_q       <= 1'b0;
		end else begin
			// Drop the result once taken, unless a new one replaces it
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (HADDR_W+1)'(HIST_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					// Latch a pushed element and, at its frame's first column, advance the frame counter
					if (accept && in_item.cmd == CMD_PUSH) begin
						len_q         <= len_c;
						rows_q        <= rows_c;
						po_q          <= po_c;
						fo_q          <= fo_c;
						col_q         <= col_c;
						sample_q      <= in_item.sample;
						frame_count_q <= fc_c;
						store_q       <= fc_c > FC_W'(warmup_q);
						nrm_q         <= newest_row_q;
						state_q       <= S_MOD;
					end
				end
				S_MOD: begin
					// Wrap the newest row into range, then advance the ring at the first column of a stored frame
					if ({1'b0, nrm_q} >= rows_q) begin
						nrm_q <= nrm_q - rows_q[PHYS_W-1:0];
					end else begin
						if (store_q && col_q == '0) begin
							nrm_q        <= nr_inc_c[PHYS_W-1:0];
							newest_row_q <= nr_inc_c[PHYS_W-1:0];
						end
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					paddr_q <= CADDR_W'(po_q - 1'b1) * CADDR_W'(len_q) + CADDR_W'(col_q);
					row_q   <= '0;
					k_q     <= '0;
					state_q <= S_PAST;
				end
				S_PAST: begin
					if (k_q == po_q - 1'b1) begin
						state_q <= S_PLAIN;
					end else begin
						k_q     <= k_q + 1'b1;
						row_q   <= row_q + ROW_W'(past_stride_q);
						paddr_q <= paddr_q - CADDR_W'(len_q);
					end
				end
				S_PLAIN: begin
					row_q   <= row_q + ROW_W'(past_stride_q);
					faddr_q <= CADDR_W'(col_q);
					k_q     <= '0;
					drain_q <= 1'b0;
					state_q <= (fo_q == '0) ? S_DRAIN : S_FUT;
				end
				S_FUT: begin
					if (k_q == fo_q - 1'b1) begin
						drain_q <= 1'b0;
						state_q <= S_DRAIN;
					end else begin
						k_q     <= k_q + 1'b1;
						row_q   <= row_q + ROW_W'(future_stride_q);
						faddr_q <= faddr_q + CADDR_W'(len_q);
					end
				end
				S_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// Hand the result over once the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q          <= 1'b1;
						out_item_q.result    <= mac_result;
						out_item_q.saturated <= mac_sat;
						out_item_q.frame_end <= ({1'b0, col_q} == len_q - 1'b1);
						column_q <= ({1'b0, col_q} + 1'b1 >= len_q) ? '0 : col_q + 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	fmb_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HIST_DEPTH)) u_hist (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	fmb_ram #(.WIDTH(COEF_BITS), .DEPTH(COEF_DEPTH)) u_past_coef (
		.clk   (clk),
		.we    (pc_we),
		.waddr (in_item.coef_addr),
		.wdata (in_item.sample),
		.raddr (paddr_q),
		.rdata (pc_rdata)
	);

	fmb_ram #(.WIDTH(COEF_BITS), .DEPTH(COEF_DEPTH)) u_fut_coef (
		.clk   (clk),
		.we    (fc_we),
		.waddr (in_item.coef_addr),
		.wdata (in_item.sample),
		.raddr (faddr_q),
		.rdata (fc_rdata)
	);

	fmb_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (mac_clear),
		.tag         (tag_c),
		.past_coef   (pc_rdata),
		.fut_coef    (fc_rdata),
		.hist_sample (h_rdata),
		.result      (mac_result),
		.saturated   (mac_sat)
	);

	// No request is taken while the history store is being cleared
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> in_stall)
		else $error("request taken during history clear");

	// A result appears only out of the writeback step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside writeback");

	// The frame counter never goes back
	a_fc_mono: assert property (@(posedge clk) disable iff (!arst_n)
		frame_count_q >= $past(frame_count_q))
		else $error("frame counter decreased");

endmodule
